// ===== rtl/lru_key_value_cache_core_assert.svh =====
// ----------------------------------------------------------------------------
// LRU key/value cache assertion macros
// Shared assertion forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define LKVC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lkvc: invariant violated");

// A consequence that must hold in the cycle after the trigger.
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lkvc: next-cycle check violated");

`endif

// ===== rtl/lkvc_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Field widths, operation codes and parameter defaults shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package lkvc_pkg;

  localparam int unsigned CAPACITY_DEF   = 16;
  localparam int unsigned KEY_BITS_DEF   = 16;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef enum logic {
    ACT_GET = 1'b0,
    ACT_PUT = 1'b1
  } action_e;

endpackage

`default_nettype wire

// ===== rtl/lkvc_if.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache channel interfaces
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkvc_req_if;
  logic                             valid;
  logic                             ready;
  lkvc_pkg::action_e                action;
  logic [lkvc_pkg::KEY_W-1:0]       lookup_key;
  logic [lkvc_pkg::VALUE_W-1:0]     write_value;

  modport source (output valid, action, lookup_key, write_value, input ready);
  modport sink   (input valid, action, lookup_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lkvc_pkg::VALUE_W-1:0]     read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/lkvc_lookup.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache lookup
// Parallel key compare over all entries with a lowest-index match, plus the
// lowest-index slot that stays free after eviction.
// ----------------------------------------------------------------------------
`default_nettype none

module lkvc_lookup #(
  parameter int unsigned CAPACITY = lkvc_pkg::CAPACITY_DEF,
  parameter int unsigned KW       = lkvc_pkg::KEY_W,
  parameter int unsigned IDX_W    = 4
) (
  input  logic [CAPACITY-1:0] valid_i,
  input  logic [KW-1:0]       keys_i [CAPACITY],
  input  logic [KW-1:0]       key_i,
  input  logic [CAPACITY-1:0] keep_i,
  output logic                found_o,
  output logic [IDX_W-1:0]    match_idx_o,
  output logic [IDX_W-1:0]    free_idx_o
);

  // Scan from the top so the lowest index wins.
  always_comb begin
    found_o     = 1'b0;
    match_idx_o = '0;
    free_idx_o  = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (valid_i[i] && (keys_i[i] == key_i)) begin
        found_o     = 1'b1;
        match_idx_o = IDX_W'(i);
      end
      if (!keep_i[i]) begin
        free_idx_o = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lru_key_value_cache_core.sv =====
// ----------------------------------------------------------------------------
// LRU key/value cache core
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one get or put item per handshake (valid && ready).
//   rsp_o returns exactly one item per request, in order: hit tells whether
//   the key was present, read_value is the stored value on a get hit and
//   zero otherwise.
//   cfg_we_i/cfg_wdata_i write active_capacity (0 acts as 1, values above
//   CAPACITY act as CAPACITY); write it only while the block is idle.
// Timing:
//   An accepted item waits in the input register; once the result register is
//   free or its item is being taken, the compare, rank update and result are
//   done in one pass into the result register, which drives the response item.
//   One item per cycle is sustained while responses are taken, set by one entry update per cycle.
// Reset:
//   All entries become invalid, the fill count clears, active_capacity
//   returns to 16. Items are accepted as soon as reset is released.
// Stall:
//   A stalled response holds; the input register still takes one more item,
//   then ready drops until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lru_key_value_cache_core_assert.svh"

module lru_key_value_cache_core #(
  parameter int unsigned CAPACITY   = lkvc_pkg::CAPACITY_DEF,
  parameter int unsigned KEY_BITS   = lkvc_pkg::KEY_BITS_DEF,
  parameter int unsigned VALUE_BITS = lkvc_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i,
  lkvc_req_if.sink                   req_i,
  lkvc_rsp_if.source                 rsp_o
);

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned RANK_W = IDX_W;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CMP_W  = (CNT_W > lkvc_pkg::CFG_W) ? CNT_W : lkvc_pkg::CFG_W;
  localparam int unsigned KW     = (KEY_BITS < lkvc_pkg::KEY_W) ? KEY_BITS : lkvc_pkg::KEY_W;
  localparam int unsigned VW     =
    (VALUE_BITS < lkvc_pkg::VALUE_W) ? VALUE_BITS : lkvc_pkg::VALUE_W;

  // Configuration.
  logic [lkvc_pkg::CFG_W-1:0] cap_q;

  // Input register.
  logic                 s1_valid_q;
  lkvc_pkg::action_e    s1_act_q;
  logic [KW-1:0]        s1_key_q;
  logic [VW-1:0]        s1_val_q;

  // Result register.
  logic                        res_valid_q;
  logic                        res_hit_q;
  logic [lkvc_pkg::VALUE_W-1:0] res_val_q;
  logic                        res_hit_d;
  logic [lkvc_pkg::VALUE_W-1:0] res_val_d;

  // Entry state.
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [RANK_W-1:0]   rank_q [CAPACITY];
  logic [RANK_W-1:0]   rank_d [CAPACITY];
  logic [CNT_W-1:0]    count_q, count_d;
  logic [KW-1:0]       key_q [CAPACITY];
  logic [VW-1:0]       value_q [CAPACITY];

  logic                advance;
  logic                is_put;
  logic                found;
  logic [IDX_W-1:0]    match_idx;
  logic [IDX_W-1:0]    free_idx;
  logic [CAPACITY-1:0] keep;
  logic [CMP_W-1:0]    cap_ext, eff_cap, cap_lim, cnt_ext, kept_cnt;
  logic [RANK_W-1:0]   hit_rank;
  logic                key_we, val_we;
  logic [IDX_W-1:0]    wr_idx;

  assign advance     = s1_valid_q && (!res_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || advance;
  assign is_put      = (s1_act_q == lkvc_pkg::ACT_PUT);

  assign rsp_o.valid      = res_valid_q;
  assign rsp_o.hit        = res_hit_q;
  assign rsp_o.read_value = res_val_q;

  // Effective capacity, clamped to 1..CAPACITY.
  always_comb begin
    cap_ext = CMP_W'(cap_q);
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(CAPACITY)) begin
      eff_cap = CMP_W'(CAPACITY);
    end else begin
      eff_cap = cap_ext;
    end
    cap_lim  = eff_cap - CMP_W'(1);
    cnt_ext  = CMP_W'(count_q);
    kept_cnt = (cnt_ext >= eff_cap) ? cap_lim : cnt_ext;
  end

  // Ranks of valid entries form 0..count-1, so evicting down to cap-1
  // entries drops exactly the valid entries ranked cap-1 or older.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      keep[i] = valid_q[i] && (CMP_W'(rank_q[i]) < cap_lim);
    end
  end

  lkvc_lookup #(
    .CAPACITY (CAPACITY),
    .KW       (KW),
    .IDX_W    (IDX_W)
  ) u_lookup (
    .valid_i     (valid_q),
    .keys_i      (key_q),
    .key_i       (s1_key_q),
    .keep_i      (keep),
    .found_o     (found),
    .match_idx_o (match_idx),
    .free_idx_o  (free_idx)
  );

  assign hit_rank = rank_q[match_idx];

  always_comb begin
    valid_d   = valid_q;
    rank_d    = rank_q;
    count_d   = count_q;
    key_we    = 1'b0;
    val_we    = 1'b0;
    wr_idx    = match_idx;
    res_hit_d = found;
    res_val_d = '0;
    if (advance) begin
      if (found) begin
        // Entries more recent than the hit age by one.
        for (int i = 0; i < CAPACITY; i++) begin
          if (valid_q[i] && (IDX_W'(i) != match_idx) && (rank_q[i] < hit_rank)) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        rank_d[match_idx] = '0;
        val_we = is_put;
        if (!is_put) begin
          res_val_d = lkvc_pkg::VALUE_W'(value_q[match_idx]);
        end
      end else if (is_put) begin
        for (int i = 0; i < CAPACITY; i++) begin
          valid_d[i] = keep[i];
          if (keep[i]) begin
            rank_d[i] = rank_q[i] + 1'b1;
          end
        end
        valid_d[free_idx] = 1'b1;
        rank_d[free_idx]  = '0;
        count_d = CNT_W'(kept_cnt + CMP_W'(1));
        key_we  = 1'b1;
        val_we  = 1'b1;
        wr_idx  = free_idx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= lkvc_pkg::CFG_RESET;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
      rank_q      <= '{default: '0};
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (req_i.valid && req_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        res_valid_q <= 1'b0;
      end
      valid_q <= valid_d;
      rank_q  <= rank_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_act_q <= req_i.action;
      s1_key_q <= req_i.lookup_key[KW-1:0];
      s1_val_q <= req_i.write_value[VW-1:0];
    end
    if (advance) begin
      res_hit_q <= res_hit_d;
      res_val_q <= res_val_d;
    end
    if (key_we) begin
      key_q[wr_idx] <= s1_key_q;
    end
    if (val_we) begin
      value_q[wr_idx] <= s1_val_q;
    end
  end

  `LKVC_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY))
  `LKVC_ASSERT_ALWAYS(a_count_matches_valid, $countones(valid_q) == int'(count_q))
  `LKVC_ASSERT_NEXT(a_hit_keeps_count, advance && found, count_q == $past(count_q))
  `LKVC_ASSERT_NEXT(a_put_miss_fills, advance && !found && is_put, count_q != '0)

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU key/value cache core testbench
// Drives get and put items through the request channel, predicts each
// response with a behavioral LRU store kept in the bench, and compares every
// response field by field. A scripted opening covers the edge cases, then
// random phases run under a range of capacity settings with random idling
// and one long response stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned SLOTS           = lkvc_pkg::CAPACITY_DEF;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned POOL_MAX        = 20;
  localparam int unsigned LONG_HOLD       = 64;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned STALL_LIMIT     = 2000;

  typedef struct packed {
    logic                         hit;
    logic [lkvc_pkg::VALUE_W-1:0] read_value;
  } lookup_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e                    kind;
    lkvc_pkg::action_e            act;
    logic [lkvc_pkg::KEY_W-1:0]   key;
    logic [lkvc_pkg::VALUE_W-1:0] val;
    bit                           typed;
    logic                         exp_hit;
    logic [lkvc_pkg::VALUE_W-1:0] exp_val;
  } script_row_t;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_we_i;
  logic [lkvc_pkg::CFG_W-1:0] cfg_wdata_i;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();

  lru_key_value_cache_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  // Bench copy of the cache contents.
  bit                           slot_used [SLOTS];
  logic [lkvc_pkg::KEY_W-1:0]   slot_key  [SLOTS];
  logic [lkvc_pkg::VALUE_W-1:0] slot_val  [SLOTS];
  int unsigned                  slot_age  [SLOTS];
  int unsigned                  fill;
  logic [lkvc_pkg::CFG_W-1:0]   capacity_reg;

  lookup_result_t pending_lookups [$];
  int unsigned    error_count;
  bit             idle_on;
  bit             hold_pending;
  int unsigned    quiet_cycles = 0;

  // Age 0 is the most recent entry.
  script_row_t script [23] = '{
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'hFFFF, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'hFFFF, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678},
    // Zero capacity acts as one, and the store is already holding two.
    '{ROW_CFG,  lkvc_pkg::ACT_GET, 16'h0000, 32'd0,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h1234, 32'hA5A5_A5A5, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h1234, 32'h0000_0000, 1'b1, 1'b1, 32'hA5A5_A5A5},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h5555, 32'h0000_0001, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h1234, 32'h0000_0000, 1'b1, 1'b0, 32'h0000_0000},
    '{ROW_CFG,  lkvc_pkg::ACT_GET, 16'h0000, 32'd31,        1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0001, 32'h1111_1111, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0002, 32'h2222_2222, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0003, 32'h3333_3333, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    // Lowering the capacity below the fill only evicts on the next put miss.
    '{ROW_CFG,  lkvc_pkg::ACT_GET, 16'h0000, 32'd2,         1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_PUT, 16'h0004, 32'h4444_4444, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0001, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000},
    '{ROW_ITEM, lkvc_pkg::ACT_GET, 16'h0002, 32'h0000_0000, 1'b0, 1'b0, 32'h0000_0000}
  };

  logic [lkvc_pkg::CFG_W-1:0] phase_caps [PHASES] = '{
    5'd16, 5'd1, 5'd4, 5'd0, 5'd2, 5'd8, 5'd31, 5'd3, 5'd17, 5'd15, 5'd5, 5'd16
  };

  function automatic lookup_result_t lru_lookup(lkvc_pkg::action_e act,
                                                logic [lkvc_pkg::KEY_W-1:0] k,
                                                logic [lkvc_pkg::VALUE_W-1:0] v);
    lookup_result_t res;
    int             found;
    int             oldest;
    int             free_slot;
    int unsigned    limit;
    int unsigned    old_age;
    found          = -1;
    res.hit        = 1'b0;
    res.read_value = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_used[i] && slot_key[i] == k) found = i;
    end
    if (found >= 0) begin
      res.hit = 1'b1;
      if (act == lkvc_pkg::ACT_GET) res.read_value = slot_val[found];
      else slot_val[found] = v;
      old_age = slot_age[found];
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && i != found && slot_age[i] < old_age) slot_age[i]++;
      end
      slot_age[found] = 0;
      return res;
    end
    if (act == lkvc_pkg::ACT_GET) return res;

    limit = (capacity_reg == 0) ? 1 : ((capacity_reg > SLOTS) ? SLOTS : capacity_reg);
    while (fill >= limit && fill > 0) begin
      oldest = -1;
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
      end
      slot_used[oldest] = 1'b0;
      fill--;
    end
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i]) slot_age[i]++;
    end
    slot_used[free_slot] = 1'b1;
    slot_key[free_slot]  = k;
    slot_val[free_slot]  = v;
    slot_age[free_slot]  = 0;
    fill++;
    return res;
  endfunction

  task automatic send_item(lkvc_pkg::action_e act, logic [lkvc_pkg::KEY_W-1:0] k,
                           logic [lkvc_pkg::VALUE_W-1:0] v, bit typed, logic exp_hit,
                           logic [lkvc_pkg::VALUE_W-1:0] exp_val);
    lookup_result_t want;
    if (idle_on && $urandom_range(0, 9) < 2) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.action      <= act;
    req_if.lookup_key  <= k;
    req_if.write_value <= v;
    do @(posedge clk_i); while (!req_if.ready);
    want = lru_lookup(act, k, v);
    if (typed) begin
      want.hit        = exp_hit;
      want.read_value = exp_val;
    end
    pending_lookups.push_back(want);
  endtask

  // The capacity is only changed once every outstanding item has come back.
  task automatic write_capacity(logic [lkvc_pkg::CFG_W-1:0] cap);
    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    capacity_reg = cap;
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Response side: random stalls, plus one long hold that backs up the block.
  initial begin
    rsp_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_pending) begin
        hold_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 9) < 2) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    lookup_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_lookups.size() == 0) begin
        $error("response item with no request outstanding");
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        if (rsp_if.hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, rsp_if.hit);
          error_count++;
        end
        if (rsp_if.read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, rsp_if.read_value);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [lkvc_pkg::KEY_W-1:0] key_pool [POOL_MAX];
    int unsigned                pool_n;
    lkvc_pkg::action_e          act;
    logic [lkvc_pkg::KEY_W-1:0] k;
    error_count  = 0;
    hold_pending = 1'b0;
    idle_on      = 1'b1;
    fill         = 0;
    capacity_reg = lkvc_pkg::CFG_RESET;
    foreach (slot_used[i]) begin
      slot_used[i] = 1'b0;
      slot_age[i]  = 0;
    end
    req_if.valid       <= 1'b0;
    req_if.action      <= lkvc_pkg::ACT_GET;
    req_if.lookup_key  <= '0;
    req_if.write_value <= '0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        write_capacity(script[r].val[lkvc_pkg::CFG_W-1:0]);
      end else begin
        send_item(script[r].act, script[r].key, script[r].val, script[r].typed,
                  script[r].exp_hit, script[r].exp_val);
      end
    end

    // Keys mostly come from a small pool per phase so that hits and
    // evictions are frequent; the rest span the whole key range.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      idle_on = (ph < PHASES - 2) && (ph % 4 != 2);
      if (ph == 1) hold_pending = 1'b1;
      pool_n = $urandom_range(2, POOL_MAX);
      foreach (key_pool[p]) key_pool[p] = $urandom_range(0, 65535);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        act = lkvc_pkg::action_e'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) k = $urandom_range(0, 65535);
        else k = key_pool[$urandom_range(0, pool_n - 1)];
        send_item(act, k, $urandom, 1'b0, 1'b0, '0);
      end
    end

    req_if.valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_lookups.size() != 0) begin
      $error("%0d response items never arrived", pending_lookups.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
